### hw/rtl/lifo_stack_with_value_removal_top_defines.svh
// Assertion macros shared by the checker of the LIFO stack with value removal.
// No dependencies; every macro samples on clk and is disabled while rst_n is low.
`ifndef LIFO_STACK_WITH_VALUE_REMOVAL_TOP_DEFINES_SVH
`define LIFO_STACK_WITH_VALUE_REMOVAL_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSVR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSVR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lsvr_pkg.sv
// Shared types for the LIFO stack with value removal.
// Used by the controller, the datapath and the top level; no dependencies.
package lsvr_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_SCAN,
        S_SHIFT
    } state_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_TOP,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_ONES,
        RD_MEM
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        ptr_op_t ptr_op;
        logic    rd_en;
        logic    wr_push;
        logic    wr_shift;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    finish;
        status_t fin_status;
        rd_sel_t fin_rd;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic ptr_zero;
        logic more;
    } dp_stat_t;

endpackage

### hw/rtl/lsvr_ctrl.sv
// Controller state machine of the LIFO stack with value removal.
// Depends on lsvr_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module lsvr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       command,
    input  lsvr_pkg::dp_stat_t stat,
    output lsvr_pkg::dp_cmd_t  cmd,
    output logic             busy
);
    import lsvr_pkg::*;

    state_t state_reg, state_next;
    cmd_t   op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= CMD_NOP;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd            = '0;
        cmd.ptr_op     = PTR_HOLD;
        cmd.fin_status = ST_OK;
        cmd.fin_rd     = RD_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd_t'(command);
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    CMD_PUSH:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                        if (stat.full)
                        begin
                            cmd.fin_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_push = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    CMD_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_EMPTY;
                            cmd.fin_rd     = RD_ONES;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_TOP;
                            cmd.rd_en  = 1'b1;
                            cmd.cnt_dec = 1'b1;
                            state_next = S_POP_WAIT;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_NOT_FOUND;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.ptr_op = PTR_TOP;
                            cmd.rd_en  = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_NOP:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP_WAIT:
            begin
                cmd.finish = 1'b1;
                cmd.fin_rd = RD_MEM;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // The entry under the pointer is in the read register this cycle.
                priority if (stat.match && stat.more)
                begin
                    cmd.ptr_op = PTR_INC;
                    cmd.rd_en  = 1'b1;
                    state_next = S_SHIFT;
                end
                else if (stat.match)
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (stat.ptr_zero)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.ptr_op = PTR_DEC;
                    cmd.rd_en  = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // Move the entry under the pointer down by one place.
                cmd.wr_shift = 1'b1;
                if (stat.more)
                begin
                    cmd.ptr_op = PTR_INC;
                    cmd.rd_en  = 1'b1;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/lsvr_datapath.sv
// Datapath of the LIFO stack with value removal: entry memory, count, pointer
// and result registers. Depends on lsvr_pkg; commanded by lsvr_ctrl.
module lsvr_datapath #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] value,
    input  lsvr_pkg::dp_cmd_t  cmd,
    output lsvr_pkg::dp_stat_t stat,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic [3:0]         depth_now
);
    import lsvr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   rd_data_reg;
    logic [31:0]   val_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          done_reg;
    logic [31:0]   read_value_reg;
    status_t       status_reg;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [CW:0]   ptr_plus1;

    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_TOP:  ptr_next = AW'(cnt_reg - CW'(1));
            PTR_DEC:  ptr_next = ptr_reg - AW'(1);
            PTR_INC:  ptr_next = ptr_reg + AW'(1);
            default:  ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    assign ptr_plus1     = (CW + 1)'(ptr_reg) + (CW + 1)'(1);
    assign stat.full     = (cnt_reg == CW'(DEPTH));
    assign stat.empty    = (cnt_reg == '0);
    assign stat.match    = (rd_data_reg == val_reg);
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.more     = (ptr_plus1 < (CW + 1)'(cnt_reg));

    // A push writes at the count, a shift writes one place below the pointer.
    assign wr_addr = cmd.wr_push ? AW'(cnt_reg) : (ptr_reg - AW'(1));
    assign wr_data = cmd.wr_push ? val_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_push || cmd.wr_shift)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[ptr_next];
        end
        if (cmd.load)
        begin
            val_reg <= value;
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
            unique case (cmd.fin_rd)
                RD_ZERO: read_value_reg <= '0;
                RD_ONES: read_value_reg <= '1;
                RD_MEM:  read_value_reg <= rd_data_reg;
                default: read_value_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            ptr_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            ptr_reg  <= ptr_next;
            done_reg <= cmd.finish;
        end
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign depth_now  = 4'(cnt_reg);

endmodule

### hw/rtl/lifo_stack_with_value_removal_top.sv
// LIFO stack with value removal. Push, the unused command, and pop or remove on an
// empty stack give their result from the execute state through the done register;
// a pop otherwise passes the pop-wait state, a remove the scan and shift states: the
// scan reads one entry per cycle from the single memory read port, then closing the
// gap moves one entry per cycle. A new transfer is taken in the cycle done is high.
// Reset (rst_n, async, active low) empties the stack; the receiver cannot stall.
module lifo_stack_with_value_removal_top #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic [3:0]         depth_now
);
    import lsvr_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    lsvr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (dp_stat),
        .cmd     (dp_cmd),
        .busy    (busy)
    );

    lsvr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .depth_now  (depth_now)
    );

endmodule

### hw/rtl/lsvr_checker.sv
// Port-level checker for the LIFO stack with value removal, bound to the top.
// Depends on lsvr_pkg and lifo_stack_with_value_removal_top_defines.svh.
`include "lifo_stack_with_value_removal_top_defines.svh"

module lsvr_checker #(
    parameter int DEPTH = 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] read_value,
    input logic [1:0]         status,
    input logic [3:0]         depth_now
);
    import lsvr_pkg::*;

    logic accepted;
    assign accepted = start && !busy;

    `LSVR_ASSERT_NEXT(a_busy_after_transfer, accepted, busy && !done, "busy not raised after transfer")
    `LSVR_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")
    `LSVR_ASSERT_SAME(a_empty_pop, done && (status == ST_EMPTY), (read_value == -32'sd1) && (depth_now == 4'd0), "empty pop result wrong")
    `LSVR_ASSERT_SAME(a_full_push, done && (status == ST_FULL), (read_value == 32'sd0) && (depth_now == 4'(DEPTH)), "full push result wrong")

endmodule

bind lifo_stack_with_value_removal_top lsvr_checker #(.DEPTH(DEPTH)) u_lsvr_checker (.*);
